// ===== hw/rtl/stsu_pkg.sv =====
// Shared types and constants for the sorted table upsert/lookup unit.
// No dependencies; imported by stsu_cell and the top level.
`timescale 1ns / 1ps

package stsu_pkg;

  localparam int STSU_DEPTH     = 16;
  localparam int STSU_KEY_BITS  = 16;
  localparam int STSU_DATA_BITS = 32;

  typedef enum logic [1:0] {
    OP_INSERT   = 2'd0,
    OP_RETRIEVE = 2'd1,
    OP_REPLACE  = 2'd2,
    OP_NOP      = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_EMPTY     = 2'd2,
    STAT_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_SEARCH,
    FSM_APPLY
  } fsm_t;

  // Command broadcast to every cell of the chain.
  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_SET_DATA,   // payload only, at slot
    CMD_SET_ENTRY,  // key and payload, at slot
    CMD_INSERT      // shift cells above slot up by one, write at slot
  } cell_cmd_t;

endpackage

// ===== hw/rtl/stsu_cell.sv =====
// One table cell: holds a key and a payload, compares against the probe key,
// and takes its lower neighbor's entry on an insert shift. Uses stsu_pkg.
`timescale 1ns / 1ps

module stsu_cell import stsu_pkg::*; #(
  parameter int IDX       = 0,
  parameter int IDX_W     = 4,
  parameter int CNT_W     = 5,
  parameter int KEY_BITS  = STSU_KEY_BITS,
  parameter int DATA_BITS = STSU_DATA_BITS
) (
  input  logic                 clk,
  input  cell_cmd_t            cmd,
  input  logic [IDX_W-1:0]     slot,
  input  logic [CNT_W-1:0]     count,
  input  logic [KEY_BITS-1:0]  key_wr,
  input  logic [DATA_BITS-1:0] data_wr,
  input  logic [KEY_BITS-1:0]  key_prev,
  input  logic [DATA_BITS-1:0] data_prev,
  output logic [KEY_BITS-1:0]  key,
  output logic [DATA_BITS-1:0] data,
  output logic                 lt,
  output logic                 eq
);

  localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

  logic sel;
  logic shift_in;

  assign sel      = (CNT_W'(slot) == MY_IDX);
  assign shift_in = (MY_IDX > CNT_W'(slot)) && (MY_IDX <= count);

  // key_wr doubles as the probe key
  assign lt = (key_wr < key);
  assign eq = (key_wr == key);

  always_ff @(posedge clk) begin
    case (cmd)
      CMD_SET_DATA: begin
        if (sel) data <= data_wr;
      end
      CMD_SET_ENTRY: begin
        if (sel) begin
          key  <= key_wr;
          data <= data_wr;
        end
      end
      CMD_INSERT: begin
        if (sel) begin
          key  <= key_wr;
          data <= data_wr;
        end else if (shift_in) begin
          key  <= key_prev;
          data <= data_prev;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== hw/rtl/sorted_table_upsert_lookup_unit.sv =====
// Sorted key/payload table (insert-or-update, retrieve, replace at cursor); top level.
// Uses stsu_pkg and a chain of DEPTH stsu_cell instances.
// Flow: replace, no-op and insert into a full table go from accept straight to the apply step;
//   a search that hits ends with its P-th probe, one that misses takes one closing step after
//   its P probes (P <= floor(log2(count))+1, at most 5 with 16 entries).
// Items: a new item is taken only after the result of the last one has been registered;
//   a stalled result holds the apply step. The search loop visits one probe per cycle.
// Reset (rst, synchronous, active high): count, cursor, FSM and output valid clear.
`timescale 1ns / 1ps

module sorted_table_upsert_lookup_unit import stsu_pkg::*; #(
  parameter int DEPTH     = STSU_DEPTH,
  parameter int KEY_BITS  = STSU_KEY_BITS,
  parameter int DATA_BITS = STSU_DATA_BITS,
  localparam int IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int POS_W    = IDX_W + 1,
  localparam int TDI_W    = ((KEY_BITS + DATA_BITS + 7) / 8) * 8,
  localparam int TDO_W    = ((POS_W + DATA_BITS + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst,
  // input item stream
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [TDI_W-1:0] s_tdata,   // key_in, data_in, zero pad
  input  logic [1:0]       s_tuser,   // opcode
  // result item stream
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [TDO_W-1:0] m_tdata,   // position, data_out, zero pad
  output logic [2:0]       m_tuser    // status, found
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SRC_W = IDX_W + 2;  // signed search bounds
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  // ---------------------------------------------------------------------------
  // Item registers and control state
  // ---------------------------------------------------------------------------
  fsm_t                     state, state_next;
  op_t                      op;
  logic [KEY_BITS-1:0]      key_r;
  logic [DATA_BITS-1:0]     data_r;
  logic signed [SRC_W-1:0]  low, high;
  logic signed [SRC_W-1:0]  pos;     // hit index, or final high bound on a miss
  logic                     hit;
  logic [CNT_W-1:0]         count;
  logic [IDX_W-1:0]         cursor;

  // result register: decouples the table from a stalled consumer
  logic                     out_valid;
  status_t                  out_status;
  logic                     out_found;
  logic [POS_W-1:0]         out_pos;
  logic [DATA_BITS-1:0]     out_data;

  logic                     in_fire;
  logic                     out_free;
  logic                     apply_fire;

  assign in_fire    = s_tvalid && s_tready;
  assign out_free   = !out_valid || m_tready;
  assign apply_fire = (state == FSM_APPLY) && out_free;

  // ---------------------------------------------------------------------------
  // Cell chain
  // ---------------------------------------------------------------------------
  cell_cmd_t             cmd;
  logic [IDX_W-1:0]      cmd_slot;
  logic [KEY_BITS-1:0]   cell_key  [DEPTH];
  logic [DATA_BITS-1:0]  cell_data [DEPTH];
  logic [DEPTH-1:0]      cell_lt, cell_eq;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [KEY_BITS-1:0]  kp;
    logic [DATA_BITS-1:0] dp;
    if (i == 0) begin : g_first
      assign kp = '0;
      assign dp = '0;
    end else begin : g_rest
      assign kp = cell_key[i-1];
      assign dp = cell_data[i-1];
    end

    stsu_cell #(
      .IDX       (i),
      .IDX_W     (IDX_W),
      .CNT_W     (CNT_W),
      .KEY_BITS  (KEY_BITS),
      .DATA_BITS (DATA_BITS)
    ) u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .slot      (cmd_slot),
      .count     (count),
      .key_wr    (key_r),
      .data_wr   (data_r),
      .key_prev  (kp),
      .data_prev (dp),
      .key       (cell_key[i]),
      .data      (cell_data[i]),
      .lt        (cell_lt[i]),
      .eq        (cell_eq[i])
    );
  end

  // ---------------------------------------------------------------------------
  // Search step: every cell compares in parallel, the probe picks one result
  // ---------------------------------------------------------------------------
  logic signed [SRC_W-1:0] mid;
  logic [IDX_W-1:0]        mid_idx;
  logic                    probe_lt, probe_eq;
  logic                    search_live;
  logic signed [SRC_W-1:0] cnt_s;

  assign search_live = (low <= high);
  assign mid         = (low + high) >>> 1;  // both bounds non-negative while live
  assign mid_idx     = mid[IDX_W-1:0];
  assign probe_lt    = cell_lt[mid_idx];
  assign probe_eq    = cell_eq[mid_idx];
  assign cnt_s       = signed'(SRC_W'(count));

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    case (state)
      FSM_IDLE: begin
        if (in_fire) begin
          // replace, no-op and a full insert need no search
          if (op_t'(s_tuser) == OP_REPLACE || op_t'(s_tuser) == OP_NOP ||
              (op_t'(s_tuser) == OP_INSERT && count == FULL_CNT)) begin
            state_next = FSM_APPLY;
          end else begin
            state_next = FSM_SEARCH;
          end
        end
      end
      FSM_SEARCH: begin
        if (!search_live || probe_eq) state_next = FSM_APPLY;
      end
      FSM_APPLY: begin
        if (out_free) state_next = FSM_IDLE;
      end
      default: state_next = FSM_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Outputs of the apply step: cell command and result fields
  // ---------------------------------------------------------------------------
  logic signed [SRC_W-1:0] ins_slot;
  logic [CNT_W-1:0]        cnt_m1;
  logic [IDX_W-1:0]        rep_idx;

  status_t                 res_status;
  logic                    res_found;
  logic [POS_W-1:0]        res_pos;
  logic [DATA_BITS-1:0]    res_data;
  logic [IDX_W-1:0]        cursor_next;
  logic [CNT_W-1:0]        count_next;

  assign ins_slot = pos + SRC_W'(1);
  assign cnt_m1   = count - CNT_W'(1);
  assign rep_idx  = (CNT_W'(cursor) >= count) ? cnt_m1[IDX_W-1:0] : cursor;

  always_comb begin
    s_tready    = (state == FSM_IDLE);
    cmd         = CMD_HOLD;
    cmd_slot    = pos[IDX_W-1:0];
    res_status  = STAT_OK;
    res_found   = 1'b0;
    res_pos     = '1;  // -1
    res_data    = '0;
    cursor_next = cursor;
    count_next  = count;
    case (op)
      OP_INSERT: begin
        if (count == FULL_CNT) begin
          res_status = STAT_FULL;
        end else if (hit) begin
          cmd         = CMD_SET_DATA;
          res_found   = 1'b1;
          res_pos     = pos[POS_W-1:0];
          cursor_next = pos[IDX_W-1:0];
        end else begin
          cmd         = CMD_INSERT;
          cmd_slot    = ins_slot[IDX_W-1:0];
          res_pos     = pos[POS_W-1:0];
          cursor_next = ins_slot[IDX_W-1:0];
          count_next  = count + CNT_W'(1);
        end
      end
      OP_RETRIEVE: begin
        res_pos = pos[POS_W-1:0];
        if (hit) begin
          res_found   = 1'b1;
          res_data    = cell_data[pos[IDX_W-1:0]];
          cursor_next = pos[IDX_W-1:0];
        end else begin
          res_status = STAT_NOT_FOUND;
        end
      end
      OP_REPLACE: begin
        if (count == '0) begin
          res_status = STAT_EMPTY;
        end else begin
          // order may break here; later searches follow the probe path as is
          cmd         = CMD_SET_ENTRY;
          cmd_slot    = rep_idx;
          res_pos     = POS_W'(rep_idx);
          cursor_next = rep_idx;
        end
      end
      default: ;  // no-op keeps everything
    endcase
    if (!apply_fire) cmd = CMD_HOLD;
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= FSM_IDLE;
      count  <= '0;
      cursor <= '0;
    end else begin
      state <= state_next;
      if (apply_fire) begin
        count  <= count_next;
        cursor <= cursor_next;
      end
    end
  end

  // item payload and search bounds
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op     <= op_t'(s_tuser);
      key_r  <= s_tdata[KEY_BITS-1:0];
      data_r <= s_tdata[KEY_BITS +: DATA_BITS];
      low    <= '0;
      high   <= cnt_s - SRC_W'(1);
      hit    <= 1'b0;
      pos    <= '1;
    end else if (state == FSM_SEARCH) begin
      if (!search_live) begin
        pos <= high;
      end else if (probe_eq) begin
        hit <= 1'b1;
        pos <= mid;
      end else if (probe_lt) begin
        high <= mid - SRC_W'(1);
      end else begin
        low <= mid + SRC_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (apply_fire) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (apply_fire) begin
      out_status <= res_status;
      out_found  <= res_found;
      out_pos    <= res_pos;
      out_data   <= res_data;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = TDO_W'({out_data, out_pos});
  assign m_tuser  = {out_found, out_status};

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_CNT)
    else $error("entry count above depth");

  a_cursor_valid: assert property (@(posedge clk) disable iff (rst)
    (count != '0) |-> (CNT_W'(cursor) < count))
    else $error("cursor outside valid entries");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> !s_tready)
    else $error("second item taken while one is in flight");

  a_insert_count: assert property (@(posedge clk) disable iff (rst)
    (apply_fire && cmd == CMD_INSERT) |=> (count == $past(count) + CNT_W'(1)))
    else $error("insert did not grow the table");

  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == FSM_APPLY))
    else $error("result issued outside apply step");
`endif

endmodule
